// ===== sv/efg_pkg.sv =====
// Package for the Ethernet frame generator: types, constants and helper functions.
package efg_pkg;

	localparam int COUNT_BITS  = 11;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int ADDR_BITS   = 6;
	localparam int DATA_BITS   = 64;

	localparam logic [63:0] HEADER_WORD = 64'hFB555555555555D5;
	localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
	localparam logic [31:0] CRC_PRESET  = 32'hFFFFFFFF;
	localparam logic [7:0]  ALIGN_FILL  = 8'h07;
	localparam logic [5:0]  MIN_CAP     = 6'd46;

	localparam logic [47:0] DEST_MAC_RST = 48'd0;
	localparam logic [47:0] SRC_MAC_RST  = 48'd0;
	localparam logic [15:0] ETYPE_RST    = 16'hAEFE;
	localparam logic [5:0]  MIN_PAY_RST  = 6'd46;
	localparam logic [10:0] MAX_PAY_RST  = 11'd1474;

	// header byte positions
	localparam logic [5:0] HDR_CRC_START = 6'd8;
	localparam logic [5:0] HDR_LAST      = 6'd21;
	localparam logic [5:0] FCS_LAST      = 6'd3;

	// input opcodes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_DATA  = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	// register indexes (byte address = 8 * index)
	localparam logic [2:0] REG_DEST_MAC = 3'd0;
	localparam logic [2:0] REG_SRC_MAC  = 3'd1;
	localparam logic [2:0] REG_ETYPE    = 3'd2;
	localparam logic [2:0] REG_MIN_PAY  = 3'd3;
	localparam logic [2:0] REG_MAX_PAY  = 3'd4;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] payload_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
		logic       bytes_dropped;
	} result_t;

	typedef struct packed {
		logic [47:0] dest_mac;
		logic [47:0] src_mac;
		logic [15:0] ether_type;
		logic [5:0]  min_payload;
		logic [10:0] max_payload;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_START,
		CMD_DATA,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic [5:0] pad;
		logic [1:0] fill;
		logic       dropped;
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR,
		PH_DATA,
		PH_PAD,
		PH_FCS,
		PH_FILL
	} phase_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// byte idx of preamble/SFD, dest, src, ethertype
	function automatic logic [7:0] hdr_byte(logic [4:0] idx, logic [47:0] d,
			logic [47:0] s, logic [15:0] et);
		logic [175:0] v;
		v = {HEADER_WORD, d, s, et} << {idx, 3'b000};
		return v[175:168];
	endfunction

endpackage

// ===== sv/efg_csr.sv =====
// Configuration registers behind the APB-style port.
module efg_csr (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [efg_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [efg_pkg::DATA_BITS-1:0]  pwdata,
	output logic [efg_pkg::DATA_BITS-1:0]  prdata,
	output logic                           pready,
	output efg_pkg::cfg_t                  cfg
);
	efg_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[5:3];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_mac    <= efg_pkg::DEST_MAC_RST;
			cfg_q.src_mac     <= efg_pkg::SRC_MAC_RST;
			cfg_q.ether_type  <= efg_pkg::ETYPE_RST;
			cfg_q.min_payload <= efg_pkg::MIN_PAY_RST;
			cfg_q.max_payload <= efg_pkg::MAX_PAY_RST;
		end else if (wr_en) begin
			unique case (idx)
				efg_pkg::REG_DEST_MAC: cfg_q.dest_mac    <= pwdata[47:0];
				efg_pkg::REG_SRC_MAC:  cfg_q.src_mac     <= pwdata[47:0];
				efg_pkg::REG_ETYPE:    cfg_q.ether_type  <= pwdata[15:0];
				efg_pkg::REG_MIN_PAY:  cfg_q.min_payload <= pwdata[5:0];
				efg_pkg::REG_MAX_PAY:  cfg_q.max_payload <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			efg_pkg::REG_DEST_MAC: prdata = {16'd0, cfg_q.dest_mac};
			efg_pkg::REG_SRC_MAC:  prdata = {16'd0, cfg_q.src_mac};
			efg_pkg::REG_ETYPE:    prdata = {48'd0, cfg_q.ether_type};
			efg_pkg::REG_MIN_PAY:  prdata = {58'd0, cfg_q.min_payload};
			efg_pkg::REG_MAX_PAY:  prdata = {53'd0, cfg_q.max_payload};
			default:               prdata = '0;
		endcase
	end
endmodule

// ===== sv/efg_front.sv =====
// Front end: accepts items, tracks frame state and turns items into commands.
module efg_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  efg_pkg::item_t item,
	input  efg_pkg::cfg_t  cfg,
	output logic          cmd_wr,
	output efg_pkg::cmd_t  cmd
);
	logic                           in_frame_q;
	logic [efg_pkg::COUNT_BITS-1:0] count_q;
	logic                           dropped_q;

	logic [efg_pkg::COUNT_BITS-1:0] max_ext;
	logic [efg_pkg::COUNT_BITS-1:0] minp_ext;
	logic [5:0]                     minp;
	logic                           short_pay;
	logic [1:0]                     len_lo;
	logic                           data_ok;

	assign minp      = (cfg.min_payload > efg_pkg::MIN_CAP) ? efg_pkg::MIN_CAP : cfg.min_payload;
	assign minp_ext  = efg_pkg::COUNT_BITS'(minp);
	assign max_ext   = efg_pkg::COUNT_BITS'(cfg.max_payload);
	assign short_pay = count_q < minp_ext;
	assign len_lo    = short_pay ? minp[1:0] : count_q[1:0];
	assign data_ok   = count_q < max_ext;

	always_comb begin
		cmd.kind    = efg_pkg::CMD_START;
		cmd.data    = item.payload_byte;
		cmd.pad     = short_pay ? (minp - count_q[5:0]) : 6'd0;
		// frame length = 26 + payload, rounded up to a multiple of four
		cmd.fill    = 2'd2 - len_lo;
		cmd.dropped = dropped_q;
		cmd_wr      = 1'b0;
		unique case (item.opcode)
			efg_pkg::OP_START: begin
				cmd.kind = efg_pkg::CMD_START;
				cmd_wr   = accept;
			end
			efg_pkg::OP_DATA: begin
				cmd.kind = efg_pkg::CMD_DATA;
				cmd_wr   = accept && in_frame_q && data_ok;
			end
			efg_pkg::OP_END: begin
				cmd.kind = efg_pkg::CMD_END;
				cmd_wr   = accept && in_frame_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			dropped_q  <= 1'b0;
		end else if (accept) begin
			unique case (item.opcode)
				efg_pkg::OP_START: begin
					in_frame_q <= 1'b1;
					count_q    <= '0;
					dropped_q  <= 1'b0;
				end
				efg_pkg::OP_DATA: begin
					if (in_frame_q) begin
						if (data_ok) begin
							count_q <= count_q + 1'b1;
						end else begin
							dropped_q <= 1'b1;
						end
					end
				end
				efg_pkg::OP_END: begin
					in_frame_q <= 1'b0;
					count_q    <= '0;
					dropped_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== sv/efg_cmd_queue.sv =====
// Short command queue between the front end and the byte sequencer.
module efg_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  efg_pkg::cmd_t wdata,
	output logic          full,
	input  logic          rd,
	output logic          valid,
	output efg_pkg::cmd_t rdata
);
	efg_pkg::cmd_t                mem [efg_pkg::QUEUE_DEPTH];
	logic [efg_pkg::QPTR_BITS-1:0] wptr_q;
	logic [efg_pkg::QPTR_BITS-1:0] rptr_q;
	logic [efg_pkg::QPTR_BITS:0]   cnt_q;
	logic                          do_wr;
	logic                          do_rd;

	assign full  = cnt_q == (efg_pkg::QPTR_BITS + 1)'(efg_pkg::QUEUE_DEPTH);
	assign valid = cnt_q != '0;
	assign rdata = mem[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ===== sv/efg_back.sv =====
// Back end: expands commands into frame bytes, runs the CRC, holds the output register.
module efg_back (
	input  logic             clk,
	input  logic             arst_n,
	input  efg_pkg::cfg_t    cfg,
	input  logic             cmd_valid,
	input  efg_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	output logic             empty,
	input  logic             pop,
	output efg_pkg::result_t result
);
	efg_pkg::phase_t  phase_q, phase_d;
	logic [5:0]       cnt_q, cnt_d;
	efg_pkg::cmd_t    cur_q;
	logic [31:0]      crc_q, crc_d;
	logic             out_valid_q;
	efg_pkg::result_t out_q;

	logic             out_ready;
	logic             emit;
	logic             done;
	logic             take;
	logic [7:0]       byte_d;
	logic             last_d;
	logic             fend_d;
	logic             crc_en;
	logic             crc_preset;
	logic [31:0]      fcs;
	logic [31:0]      fcs_sh;

	assign out_ready = !out_valid_q || pop;
	assign emit      = (phase_q != efg_pkg::PH_IDLE) && out_ready;
	assign done      = (emit && last_d) || (phase_q == efg_pkg::PH_IDLE);
	assign take      = done && cmd_valid;
	assign cmd_pop   = take;
	assign empty     = !out_valid_q;
	assign result    = out_q;
	assign fcs       = ~crc_q;
	assign fcs_sh    = fcs >> {cnt_q[1:0], 3'b000};

	// byte, CRC step and flags for the current phase
	always_comb begin
		byte_d     = 8'd0;
		last_d     = 1'b0;
		fend_d     = 1'b0;
		crc_en     = 1'b0;
		crc_preset = 1'b0;
		unique case (phase_q)
			efg_pkg::PH_IDLE: ;
			efg_pkg::PH_HDR: begin
				byte_d     = efg_pkg::hdr_byte(cnt_q[4:0], cfg.dest_mac, cfg.src_mac,
						cfg.ether_type);
				crc_preset = cnt_q < efg_pkg::HDR_CRC_START;
				crc_en     = !crc_preset;
				last_d     = cnt_q == efg_pkg::HDR_LAST;
			end
			efg_pkg::PH_DATA: begin
				byte_d = cur_q.data;
				crc_en = 1'b1;
				last_d = 1'b1;
			end
			efg_pkg::PH_PAD: begin
				crc_en = 1'b1;
			end
			efg_pkg::PH_FCS: begin
				byte_d = fcs_sh[7:0];
				last_d = (cnt_q == efg_pkg::FCS_LAST) && (cur_q.fill == 2'd0);
				fend_d = last_d;
			end
			efg_pkg::PH_FILL: begin
				byte_d = efg_pkg::ALIGN_FILL;
				last_d = cnt_q == 6'd1;
				fend_d = last_d;
			end
			default: ;
		endcase
	end

	always_comb begin
		crc_d = crc_q;
		if (emit) begin
			if (crc_preset) begin
				crc_d = efg_pkg::CRC_PRESET;
			end else if (crc_en) begin
				crc_d = efg_pkg::crc_byte(crc_q, byte_d);
			end
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		if (take) begin
			cnt_d = 6'd0;
			unique case (cmd.kind)
				efg_pkg::CMD_START: phase_d = efg_pkg::PH_HDR;
				efg_pkg::CMD_DATA:  phase_d = efg_pkg::PH_DATA;
				efg_pkg::CMD_END: begin
					if (cmd.pad != 6'd0) begin
						phase_d = efg_pkg::PH_PAD;
						cnt_d   = cmd.pad;
					end else begin
						phase_d = efg_pkg::PH_FCS;
					end
				end
				default: phase_d = efg_pkg::PH_IDLE;
			endcase
		end else if (done) begin
			phase_d = efg_pkg::PH_IDLE;
		end else if (emit) begin
			unique case (phase_q)
				efg_pkg::PH_HDR: cnt_d = cnt_q + 1'b1;
				efg_pkg::PH_PAD: begin
					if (cnt_q == 6'd1) begin
						phase_d = efg_pkg::PH_FCS;
						cnt_d   = 6'd0;
					end else begin
						cnt_d = cnt_q - 1'b1;
					end
				end
				efg_pkg::PH_FCS: begin
					if (cnt_q == efg_pkg::FCS_LAST) begin
						phase_d = efg_pkg::PH_FILL;
						cnt_d   = {4'd0, cur_q.fill};
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
				efg_pkg::PH_FILL: cnt_d = cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= efg_pkg::PH_IDLE;
			cnt_q       <= '0;
			crc_q       <= efg_pkg::CRC_PRESET;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			crc_q   <= crc_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= cmd;
		end
		if (emit) begin
			out_q.out_byte      <= byte_d;
			out_q.run_last      <= last_d;
			out_q.frame_end     <= fend_d;
			out_q.bytes_dropped <= fend_d && cur_q.dropped;
		end
	end
endmodule

// ===== sv/ethernet_frame_generator_top.sv =====
// Top level of the Ethernet frame generator.
//
//  channel  | handshake          | payload            | notes
//  ---------+--------------------+--------------------+------------------------------
//  input    | push / full        | item (item_t)      | start, data byte, end
//  result   | empty / pop        | result (result_t)  | one frame byte per transaction
//  config   | psel/penable/...   | pwdata / prdata    | 8-byte register stride
//
// One item is taken per cycle while the 4-entry command queue has room.
// The byte sequencer emits one frame byte per cycle unless pop stalls it: a start
// yields 22 bytes, a data byte one, an end 4 to 50 (padding, FCS, alignment fill);
// the sequencer sets the rate. The output register is refilled in the cycle it is popped;
// pop low stalls the sequencer, and full rises once the queue backs up. Reset is
// asynchronous and leaves no frame open with the registers at their defaults.
module ethernet_frame_generator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  efg_pkg::item_t                item,
	output logic                          empty,
	input  logic                          pop,
	output efg_pkg::result_t              result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [efg_pkg::ADDR_BITS-1:0] paddr,
	input  logic [efg_pkg::DATA_BITS-1:0] pwdata,
	output logic [efg_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready
);
	efg_pkg::cfg_t cfg;
	efg_pkg::cmd_t cmd_in;
	efg_pkg::cmd_t cmd_out;
	logic          cmd_wr;
	logic          cmd_valid;
	logic          cmd_pop;
	logic          accept;

	assign accept = push && !full;

	efg_csr u_csr (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	efg_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg),
		.cmd_wr (cmd_wr),
		.cmd    (cmd_in)
	);

	efg_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_wr),
		.wdata  (cmd_in),
		.full   (full),
		.rd     (cmd_pop),
		.valid  (cmd_valid),
		.rdata  (cmd_out)
	);

	efg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);
endmodule

// ===== sv/efg_checker.sv =====
// Port-level checks for the Ethernet frame generator, bound to the top level.
module efg_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input efg_pkg::result_t result
);
	// nothing shown to the consumer once reset has been seen
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result visible during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

	// the frame's final byte always closes its end transaction
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.frame_end) |-> result.run_last)
		else $error("frame_end without run_last");

	a_drop_end: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.bytes_dropped) |-> result.frame_end)
		else $error("bytes_dropped outside the final byte");
endmodule

bind ethernet_frame_generator_top efg_checker u_efg_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
